// ===== rtl/russian_light_suffix_stemmer_defines.svh =====
// ----------------------------------------------------------------------------
// russian light suffix stemmer assertion macros
// shared concurrent property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef RUSSIAN_LIGHT_SUFFIX_STEMMER_DEFINES_SVH
`define RUSSIAN_LIGHT_SUFFIX_STEMMER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RLSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RLSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rlss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_pkg
// letter codes, ending tables and shared types of the light suffix stemmer
// ----------------------------------------------------------------------------
package rlss_pkg;

	localparam int unsigned LEN_W        = 8;
	localparam int unsigned CHAR_W       = 16;
	localparam int unsigned TAIL_N       = 6;
	localparam int unsigned CUT_W        = 3;
	localparam int unsigned TDATA_IN_W   = 104;
	localparam int unsigned TDATA_OUT_W  = 8;
	localparam int unsigned MAX_WORD_LEN = 255;

	// cyrillic code units
	localparam logic [CHAR_W-1:0] C_A    = 16'h0430;
	localparam logic [CHAR_W-1:0] C_V    = 16'h0432;
	localparam logic [CHAR_W-1:0] C_G    = 16'h0433;
	localparam logic [CHAR_W-1:0] C_E    = 16'h0435;
	localparam logic [CHAR_W-1:0] C_I    = 16'h0438;
	localparam logic [CHAR_W-1:0] C_IK   = 16'h0439;
	localparam logic [CHAR_W-1:0] C_M    = 16'h043C;
	localparam logic [CHAR_W-1:0] C_N    = 16'h043D;
	localparam logic [CHAR_W-1:0] C_O    = 16'h043E;
	localparam logic [CHAR_W-1:0] C_R    = 16'h0440;
	localparam logic [CHAR_W-1:0] C_U    = 16'h0443;
	localparam logic [CHAR_W-1:0] C_KH   = 16'h0445;
	localparam logic [CHAR_W-1:0] C_Y    = 16'h044B;
	localparam logic [CHAR_W-1:0] C_SOFT = 16'h044C;
	localparam logic [CHAR_W-1:0] C_YU   = 16'h044E;
	localparam logic [CHAR_W-1:0] C_YA   = 16'h044F;
	localparam logic [CHAR_W-1:0] C_YO   = 16'h0451;

	// element 0 is the last code unit of the word
	typedef logic [TAIL_N-1:0][CHAR_W-1:0] tail_t;

	// case-removal result handed to normalization
	typedef struct packed {
		logic [CUT_W-1:0] cut;
		logic [LEN_W-1:0] len;
	} cut_t;

	localparam int unsigned END4_N = 2;
	localparam int unsigned END3_N = 15;
	localparam int unsigned END2_N = 30;

	// endings in reading order
	localparam logic [CHAR_W-1:0] END4 [END4_N][4] = '{
		'{C_I, C_YA, C_M, C_I}, '{C_O, C_YA, C_M, C_I}
	};

	localparam logic [CHAR_W-1:0] END3 [END3_N][3] = '{
		'{C_I, C_YA, C_M}, '{C_I, C_YA, C_KH}, '{C_O, C_YA, C_KH},
		'{C_YA, C_M, C_I}, '{C_O, C_YA, C_M}, '{C_O, C_SOFT, C_V},
		'{C_A, C_M, C_I}, '{C_E, C_G, C_O}, '{C_E, C_M, C_U},
		'{C_E, C_R, C_I}, '{C_I, C_M, C_I}, '{C_O, C_G, C_O},
		'{C_O, C_M, C_U}, '{C_Y, C_M, C_I}, '{C_O, C_E, C_V}
	};

	localparam logic [CHAR_W-1:0] END2 [END2_N][2] = '{
		'{C_A, C_YA}, '{C_YA, C_YA}, '{C_YA, C_KH}, '{C_YU, C_YU}, '{C_A, C_KH},
		'{C_E, C_YU}, '{C_I, C_KH}, '{C_I, C_YA}, '{C_I, C_YU}, '{C_SOFT, C_V},
		'{C_O, C_YU}, '{C_U, C_YU}, '{C_YA, C_M}, '{C_Y, C_KH}, '{C_E, C_YA},
		'{C_A, C_M}, '{C_E, C_M}, '{C_E, C_IK}, '{C_YO, C_M}, '{C_E, C_V},
		'{C_I, C_IK}, '{C_I, C_M}, '{C_O, C_E}, '{C_O, C_IK}, '{C_O, C_M},
		'{C_O, C_V}, '{C_Y, C_E}, '{C_Y, C_IK}, '{C_Y, C_M}, '{C_M, C_I}
	};

	function automatic logic any_end4(tail_t t);
		logic hit;
		logic m;
		hit = 1'b0;
		for (int k = 0; k < END4_N; k++) begin
			m = 1'b1;
			for (int i = 0; i < 4; i++) begin
				m &= (t[i] == END4[k][3-i]);
			end
			hit |= m;
		end
		return hit;
	endfunction

	function automatic logic any_end3(tail_t t);
		logic hit;
		logic m;
		hit = 1'b0;
		for (int k = 0; k < END3_N; k++) begin
			m = 1'b1;
			for (int i = 0; i < 3; i++) begin
				m &= (t[i] == END3[k][2-i]);
			end
			hit |= m;
		end
		return hit;
	endfunction

	function automatic logic any_end2(tail_t t);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < END2_N; k++) begin
			hit |= (t[0] == END2[k][1]) && (t[1] == END2[k][0]);
		end
		return hit;
	endfunction

	function automatic logic vowelish(logic [CHAR_W-1:0] c);
		return (c == C_A) || (c == C_E) || (c == C_I) || (c == C_O) || (c == C_U) ||
			(c == C_IK) || (c == C_Y) || (c == C_YA) || (c == C_SOFT);
	endfunction

endpackage

// ===== rtl/rlss_strip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_strip
// clamps the length and picks the case ending to remove
// ----------------------------------------------------------------------------
module rlss_strip (
	input  logic [rlss_pkg::LEN_W-1:0] word_len,
	input  rlss_pkg::tail_t            tail,
	output rlss_pkg::cut_t             cut_info
);

	logic [rlss_pkg::LEN_W-1:0] len_c;
	logic                       m4, m3, m2, m1;

	always_comb begin
		if (32'(word_len) > rlss_pkg::MAX_WORD_LEN) begin
			len_c = rlss_pkg::LEN_W'(rlss_pkg::MAX_WORD_LEN);
		end else begin
			len_c = word_len;
		end
	end

	assign m4 = (len_c > 8'd6) && rlss_pkg::any_end4(tail);
	assign m3 = (len_c > 8'd5) && rlss_pkg::any_end3(tail);
	assign m2 = (len_c > 8'd4) && rlss_pkg::any_end2(tail);
	assign m1 = (len_c > 8'd3) && rlss_pkg::vowelish(tail[0]);

	// longest ending wins
	always_comb begin
		cut_info.len = len_c;
		priority if (m4) begin
			cut_info.cut = 3'd4;
		end else if (m3) begin
			cut_info.cut = 3'd3;
		end else if (m2) begin
			cut_info.cut = 3'd2;
		end else if (m1) begin
			cut_info.cut = 3'd1;
		end else begin
			cut_info.cut = 3'd0;
		end
	end

endmodule

// ===== rtl/rlss_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_norm
// applies the cut and drops a final soft sign, i or doubled n
// ----------------------------------------------------------------------------
module rlss_norm (
	input  rlss_pkg::tail_t            tail,
	input  rlss_pkg::cut_t             cut_info,
	output logic [rlss_pkg::LEN_W-1:0] stem_len
);

	logic [rlss_pkg::LEN_W-1:0]  len_cut;
	logic [rlss_pkg::CHAR_W-1:0] last_c, prev_c;
	logic                        drop;

	assign len_cut = cut_info.len - rlss_pkg::LEN_W'(cut_info.cut);

	// new last unit and the one before it
	always_comb begin
		unique case (cut_info.cut)
			3'd0: begin
				last_c = tail[0];
				prev_c = tail[1];
			end
			3'd1: begin
				last_c = tail[1];
				prev_c = tail[2];
			end
			3'd2: begin
				last_c = tail[2];
				prev_c = tail[3];
			end
			3'd3: begin
				last_c = tail[3];
				prev_c = tail[4];
			end
			3'd4: begin
				last_c = tail[4];
				prev_c = tail[5];
			end
			default: begin
				last_c = tail[0];
				prev_c = tail[1];
			end
		endcase
	end

	assign drop = (len_cut > 8'd3) &&
		((last_c == rlss_pkg::C_SOFT) || (last_c == rlss_pkg::C_I) ||
		 ((last_c == rlss_pkg::C_N) && (prev_c == rlss_pkg::C_N)));

	assign stem_len = drop ? (len_cut - 8'd1) : len_cut;

endmodule

// ===== rtl/russian_light_suffix_stemmer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// russian_light_suffix_stemmer
// light russian stemmer: word length and last six units in, stem length out
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[103:0] word_len, char_last_1..6
// m_       out  m_tvalid/m_tready  m_tdata[7:0]   stem_len
//
// one transaction per cycle sustained while m_ is not stalled
// the single stemming pass lies between the input register
// and the result register
// arst_n clears both valid flags; payload registers are not reset
// a stall on m_ holds the result; a stalled input stage drops s_tready
//
module russian_light_suffix_stemmer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// word_len[7:0], char_last_1[23:8] .. char_last_6[103:88]
	input  logic [rlss_pkg::TDATA_IN_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// stem_len[7:0]
	output logic [rlss_pkg::TDATA_OUT_W-1:0] m_tdata
);

	// input stage
	logic                       valid_s1;
	logic [rlss_pkg::LEN_W-1:0] len_s1;
	rlss_pkg::tail_t            tail_s1;

	// result stage
	logic                       valid_s2;
	logic [rlss_pkg::LEN_W-1:0] stem_len_s2;

	rlss_pkg::cut_t             cut_info;
	logic [rlss_pkg::LEN_W-1:0] stem_len;
	logic                       adv_s2;

	// the result stage takes a word when it is empty or being drained
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			len_s1  <= s_tdata[rlss_pkg::LEN_W-1:0];
			tail_s1 <= rlss_pkg::tail_t'(s_tdata[rlss_pkg::TDATA_IN_W-1:rlss_pkg::LEN_W]);
		end
	end

	// case ending removal
	rlss_strip u_strip (
		.word_len (len_s1),
		.tail     (tail_s1),
		.cut_info (cut_info)
	);

	// final soft sign, i and double n
	rlss_norm u_norm (
		.tail     (tail_s1),
		.cut_info (cut_info),
		.stem_len (stem_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			stem_len_s2 <= stem_len;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = stem_len_s2;

endmodule

// ===== rtl/rlss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_checker
// port-level checks of the stemmer, bound to the top level
// ----------------------------------------------------------------------------
`include "russian_light_suffix_stemmer_defines.svh"

module rlss_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [rlss_pkg::TDATA_OUT_W-1:0] m_tdata
);

	logic [1:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`RLSS_ASSERT_NOW(a_pending_max, 1'b1, pending_q <= 2'd2, "more than two words in flight")
	`RLSS_ASSERT_NOW(a_no_phantom, pending_q == 2'd0, !m_tvalid, "result with no word pending")
	`RLSS_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled while output free")
	`RLSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind russian_light_suffix_stemmer rlss_checker u_rlss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
